// ===== hdl/rsi_pkg.sv =====
// Shared types, widths, constants and step functions for the ray/sphere intersection unit.
package rsi_pkg;

    // Field widths
    localparam int CoordW  = 32;
    localparam int RadW    = 31;
    localparam int LW      = CoordW + 1;     // origin minus center
    localparam int AW      = 64;             // a = d.d, unsigned
    localparam int HW      = 66;             // h = d.L, signed
    localparam int CW      = 67;             // c = L.L - r*r, signed
    localparam int SqW     = 130;            // h*h and a*|c| magnitudes
    localparam int DiscW   = 126;            // nonnegative discriminant
    localparam int RootW   = DiscW / 2;      // integer square root bits
    localparam int RemW    = RootW + 2;      // square root remainder
    localparam int NumW    = 67;             // root numerators, signed
    localparam int QW      = 32;             // unsigned quotient bits
    localparam int DivSteps = QW;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_CENTER_Z = 2'd2;
    localparam logic [1:0] REG_RADIUS   = 2'd3;

    // Hit count codes
    localparam logic [1:0] HIT_NONE = 2'd0;
    localparam logic [1:0] HIT_ONE  = 2'd1;
    localparam logic [1:0] HIT_TWO  = 2'd2;

    localparam logic signed [31:0] T_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] T_MIN = 32'sh80000000;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } ray_t;

    typedef struct packed {
        logic [1:0]         hit_count;
        logic signed [31:0] t_near;
        logic signed [31:0] t_far;
    } hit_t;

    // Values that ride along with the square root
    typedef struct packed {
        logic signed [HW-1:0] h;
        logic [AW-1:0]        a;
        logic                 miss;
    } coef_t;

    // One square root stage
    typedef struct packed {
        logic [DiscW-1:0] x;
        logic [RemW-1:0]  rem;
        logic [RootW-1:0] root;
        coef_t            coef;
    } sq_t;

    // One divider lane
    typedef struct packed {
        logic [AW-1:0] rem;
        logic [QW-1:0] q;
        logic [QW-1:0] n;
        logic          neg;
        logic          ovf;
    } dl_t;

    // One divider stage: both roots share the divisor
    typedef struct packed {
        logic [AW-1:0]   a;
        logic            miss;
        dl_t [1:0]       lane;
    } dv_t;

    // One digit of the restoring square root
    function automatic sq_t sqrt_step(sq_t s);
        sq_t             r;
        logic [RemW-1:0] cur;
        logic [RemW-1:0] trial;
        r     = s;
        cur   = {s.rem[RemW-3:0], s.x[DiscW-1 -: 2]};
        trial = {s.root, 2'b01};
        if (cur >= trial)
        begin
            r.rem  = cur - trial;
            r.root = {s.root[RootW-2:0], 1'b1};
        end
        else
        begin
            r.rem  = cur;
            r.root = {s.root[RootW-2:0], 1'b0};
        end
        r.x = {s.x[DiscW-3:0], 2'b00};
        return r;
    endfunction

    // One quotient bit of the restoring divider, both lanes
    function automatic dv_t div_step(dv_t s);
        dv_t         r;
        logic [AW:0] cur;
        logic [AW:0] diff;
        r = s;
        for (int i = 0; i < 2; i++)
        begin
            cur  = {s.lane[i].rem, s.lane[i].n[QW-1]};
            diff = cur - {1'b0, s.a};
            if (cur >= {1'b0, s.a})
            begin
                r.lane[i].rem = diff[AW-1:0];
                r.lane[i].q   = {s.lane[i].q[QW-2:0], 1'b1};
            end
            else
            begin
                r.lane[i].rem = cur[AW-1:0];
                r.lane[i].q   = {s.lane[i].q[QW-2:0], 1'b0};
            end
            r.lane[i].n = {s.lane[i].n[QW-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== hdl/rsi_quad.sv =====
// Coefficient and discriminant pipeline: a, h, c and h*h - a*c in six stages.
module rsi_quad (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  rsi_pkg::ray_t                      ray,
    input  logic signed [rsi_pkg::CoordW-1:0]  center_x,
    input  logic signed [rsi_pkg::CoordW-1:0]  center_y,
    input  logic signed [rsi_pkg::CoordW-1:0]  center_z,
    input  logic [rsi_pkg::RadW-1:0]           radius,
    output logic                               out_valid,
    output logic [rsi_pkg::DiscW-1:0]          disc,
    output rsi_pkg::coef_t                     coef
);
    import rsi_pkg::*;

    logic [5:0] vld_reg;

    // stage 1: offsets
    logic signed [LW-1:0]     l_reg [3];
    logic signed [LW-1:0]     l_next [3];
    logic signed [CoordW-1:0] d_reg [3];
    logic [RadW-1:0]          r_reg;

    // stage 2: products
    logic signed [63:0] dd_reg [3];
    logic signed [64:0] dl_reg [3];
    logic signed [65:0] ll_reg [3];
    logic [61:0]        r2_reg;

    // stage 3: coefficients
    logic [AW-1:0]        a3_reg;
    logic [AW-1:0]        a3_next;
    logic signed [HW-1:0] h3_reg;
    logic signed [HW-1:0] h3_next;
    logic signed [CW-1:0] c3_reg;
    logic signed [CW-1:0] c3_next;

    // stage 4: partial products of h*h and a*|c|
    logic signed [HW-1:0] h_abs_full;
    logic signed [CW-1:0] c_abs_full;
    logic [64:0]          h_abs;
    logic [65:0]          c_abs;
    logic [63:0]          p_hh_reg;
    logic [64:0]          p_hm_reg;
    logic [65:0]          p_ll_reg;
    logic [64:0]          p_ac11_reg;
    logic [64:0]          p_ac10_reg;
    logic [64:0]          p_ac01_reg;
    logic [64:0]          p_ac00_reg;
    logic                 cneg4_reg;
    logic [AW-1:0]        a4_reg;
    logic signed [HW-1:0] h4_reg;

    // stage 5: summed squares
    logic [SqW-1:0]       hsq_reg;
    logic [SqW-1:0]       hsq_next;
    logic [SqW-1:0]       ac_reg;
    logic [SqW-1:0]       ac_next;
    logic                 cneg5_reg;
    logic [AW-1:0]        a5_reg;
    logic signed [HW-1:0] h5_reg;

    // stage 6: discriminant
    logic signed [SqW:0]  disc_next;
    logic [DiscW-1:0]     disc_reg;
    coef_t                coef_reg;
    coef_t                coef_next;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[4:0], in_valid};
    end

    // stage 1
    always_comb
    begin
        l_next[0] = LW'(ray.origin_x) - LW'(center_x);
        l_next[1] = LW'(ray.origin_y) - LW'(center_y);
        l_next[2] = LW'(ray.origin_z) - LW'(center_z);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                l_reg[i] <= l_next[i];
            d_reg[0] <= ray.dir_x;
            d_reg[1] <= ray.dir_y;
            d_reg[2] <= ray.dir_z;
            r_reg    <= radius;
        end
    end

    // stage 2
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dd_reg[i] <= 64'(d_reg[i]) * 64'(d_reg[i]);
                dl_reg[i] <= 65'(d_reg[i]) * 65'(l_reg[i]);
                ll_reg[i] <= 66'(l_reg[i]) * 66'(l_reg[i]);
            end
            r2_reg <= 62'(r_reg) * 62'(r_reg);
        end
    end

    // stage 3
    always_comb
    begin
        a3_next = $unsigned(dd_reg[0]) + $unsigned(dd_reg[1]) + $unsigned(dd_reg[2]);
        h3_next = HW'(dl_reg[0]) + HW'(dl_reg[1]) + HW'(dl_reg[2]);
        c3_next = CW'(ll_reg[0]) + CW'(ll_reg[1]) + CW'(ll_reg[2])
                  - $signed({5'b0, r2_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a3_reg <= a3_next;
            h3_reg <= h3_next;
            c3_reg <= c3_next;
        end
    end

    // stage 4: magnitudes split into 32/33 bit limbs
    always_comb
    begin
        h_abs_full = h3_reg[HW-1] ? -h3_reg : h3_reg;
        c_abs_full = c3_reg[CW-1] ? -c3_reg : c3_reg;
        h_abs      = h_abs_full[64:0];
        c_abs      = c_abs_full[65:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_hh_reg   <= 64'(h_abs[64:33]) * 64'(h_abs[64:33]);
            p_hm_reg   <= 65'(h_abs[64:33]) * 65'(h_abs[32:0]);
            p_ll_reg   <= 66'(h_abs[32:0]) * 66'(h_abs[32:0]);
            p_ac11_reg <= 65'(a3_reg[63:32]) * 65'(c_abs[65:33]);
            p_ac10_reg <= 65'(a3_reg[63:32]) * 65'(c_abs[32:0]);
            p_ac01_reg <= 65'(a3_reg[31:0]) * 65'(c_abs[65:33]);
            p_ac00_reg <= 65'(a3_reg[31:0]) * 65'(c_abs[32:0]);
            cneg4_reg  <= c3_reg[CW-1];
            a4_reg     <= a3_reg;
            h4_reg     <= h3_reg;
        end
    end

    // stage 5: recombine partial products
    always_comb
    begin
        hsq_next = (SqW'(p_hh_reg) << 66) + (SqW'(p_hm_reg) << 34) + SqW'(p_ll_reg);
        ac_next  = (SqW'(p_ac11_reg) << 65) + (SqW'(p_ac10_reg) << 32)
                   + (SqW'(p_ac01_reg) << 33) + SqW'(p_ac00_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hsq_reg   <= hsq_next;
            ac_reg    <= ac_next;
            cneg5_reg <= cneg4_reg;
            a5_reg    <= a4_reg;
            h5_reg    <= h4_reg;
        end
    end

    // stage 6: disc = h*h - a*c, miss on negative disc or zero direction
    always_comb
    begin
        if (cneg5_reg)
            disc_next = $signed({1'b0, hsq_reg}) + $signed({1'b0, ac_reg});
        else
            disc_next = $signed({1'b0, hsq_reg}) - $signed({1'b0, ac_reg});
        coef_next.h    = h5_reg;
        coef_next.a    = a5_reg;
        coef_next.miss = disc_next[SqW] || (a5_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            disc_reg <= disc_next[DiscW-1:0];
            coef_reg <= coef_next;
        end
    end

    assign out_valid = vld_reg[5];
    assign disc      = disc_reg;
    assign coef      = coef_reg;

endmodule

// ===== hdl/rsi_sqrt.sv =====
// Integer square root pipeline: one result bit per stage.
module rsi_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [rsi_pkg::DiscW-1:0]  disc,
    input  rsi_pkg::coef_t             in_coef,
    output logic                       out_valid,
    output logic [rsi_pkg::RootW-1:0]  root,
    output rsi_pkg::coef_t             out_coef
);
    import rsi_pkg::*;

    logic [RootW-1:0] vld_reg;
    sq_t              st_reg [RootW];
    sq_t              init;

    always_comb
    begin
        init.x    = disc;
        init.rem  = '0;
        init.root = '0;
        init.coef = in_coef;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[RootW-2:0], in_valid};
    end

    // digit stages
    for (genvar k = 0; k < RootW; k++)
    begin : g_stage
        sq_t st_in;
        sq_t st_next;
        if (k == 0)
        begin : g_first
            assign st_in = init;
        end
        else
        begin : g_rest
            assign st_in = st_reg[k-1];
        end
        assign st_next = sqrt_step(st_in);
        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[k] <= st_next;
        end
    end

    assign out_valid = vld_reg[RootW-1];
    assign root      = st_reg[RootW-1].root;
    assign out_coef  = st_reg[RootW-1].coef;

endmodule

// ===== hdl/rsi_div.sv =====
// Root divider: numerators -h -/+ s scaled by the fraction bits, floored over a, saturated.
module rsi_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [rsi_pkg::RootW-1:0]  root,
    input  rsi_pkg::coef_t             coef,
    output logic                       out_valid,
    output logic                       miss,
    output logic signed [31:0]         t0,
    output logic signed [31:0]         t1
);
    import rsi_pkg::*;

    localparam int NW   = NumW + FRAC_BITS;
    localparam int HiW  = NW - QW;
    localparam int NSt  = DivSteps + 3;

    logic [NSt-1:0] vld_reg;

    // stage A: numerators
    logic signed [NumW-1:0] num_reg [2];
    logic signed [NumW-1:0] num_next [2];
    logic signed [NumW-1:0] hx;
    logic signed [NumW-1:0] sx;
    logic [AW-1:0]          a_a_reg;
    logic                   miss_a_reg;

    // stage B: magnitude, scaling, range check
    dv_t                    init_reg;
    dv_t                    init_next;
    logic [NumW-1:0]        mag [2];
    logic [NW-1:0]          nsc [2];

    // quotient stages
    dv_t                    st_reg [DivSteps];
    dv_t                    last;

    // final stage
    logic signed [31:0]     t_reg [2];
    logic signed [31:0]     t_next [2];
    logic signed [QW+1:0]   qs [2];
    logic                   miss_f_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSt-2:0], in_valid};
    end

    // stage A
    always_comb
    begin
        hx          = NumW'(coef.h);
        sx          = $signed({{(NumW-RootW){1'b0}}, root});
        num_next[0] = -hx - sx;
        num_next[1] = sx - hx;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0] <= num_next[0];
            num_reg[1] <= num_next[1];
            a_a_reg    <= coef.a;
            miss_a_reg <= coef.miss;
        end
    end

    // stage B
    always_comb
    begin
        init_next.a    = a_a_reg;
        init_next.miss = miss_a_reg;
        for (int i = 0; i < 2; i++)
        begin
            mag[i] = num_reg[i][NumW-1] ? $unsigned(-num_reg[i]) : $unsigned(num_reg[i]);
            nsc[i] = {mag[i], {FRAC_BITS{1'b0}}};
            init_next.lane[i].neg = num_reg[i][NumW-1];
            init_next.lane[i].ovf = {{(AW-HiW){1'b0}}, nsc[i][NW-1:QW]} >= a_a_reg;
            init_next.lane[i].rem = {{(AW-HiW){1'b0}}, nsc[i][NW-1:QW]};
            init_next.lane[i].q   = '0;
            init_next.lane[i].n   = nsc[i][QW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            init_reg <= init_next;
    end

    // quotient bit stages
    for (genvar k = 0; k < DivSteps; k++)
    begin : g_stage
        dv_t st_in;
        dv_t st_next;
        if (k == 0)
        begin : g_first
            assign st_in = init_reg;
        end
        else
        begin : g_rest
            assign st_in = st_reg[k-1];
        end
        assign st_next = div_step(st_in);
        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[k] <= st_next;
        end
    end

    assign last = st_reg[DivSteps-1];

    // final stage: floor toward minus infinity and saturate
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (last.lane[i].neg)
                qs[i] = -$signed({2'b00, last.lane[i].q})
                        - $signed({{(QW+1){1'b0}}, (last.lane[i].rem != '0)});
            else
                qs[i] = $signed({2'b00, last.lane[i].q});
            if (last.lane[i].ovf)
                t_next[i] = last.lane[i].neg ? T_MIN : T_MAX;
            else if (qs[i] > $signed({2'b00, T_MAX}))
                t_next[i] = T_MAX;
            else if (qs[i] < $signed({2'b11, T_MIN}))
                t_next[i] = T_MIN;
            else
                t_next[i] = qs[i][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0]   <= t_next[0];
            t_reg[1]   <= t_next[1];
            miss_f_reg <= last.miss;
        end
    end

    assign out_valid = vld_reg[NSt-1];
    assign miss      = miss_f_reg;
    assign t0        = t_reg[0];
    assign t1        = t_reg[1];

endmodule

// ===== hdl/ray_sphere_intersect.sv =====
// Top level of the ray/sphere intersection unit: register port, pipeline and result register.
//
// Usage: write the sphere center (center_x/y/z, signed Q16.16) and radius
// (unsigned Q15.16) over the APB port at byte addresses 0x0, 0x4, 0x8, 0xC
// while no ray is in flight. Rays enter on in_valid/in_ready as in_data
// (origin and direction); each ray gives exactly one item on
// out_valid/out_ready: hit_count, t_near and t_far (zero where not valid).
// Throughput is one ray per cycle unless the pipeline holds. The path
// holds 105 register stages: 6 coefficient stages, 63 square root stages
// (one root bit each), 35 divider stages (32 quotient bits plus setup
// and rounding) and the result register. The whole pipeline moves as
// one: when a result sits in the output register and out_ready is low,
// every stage holds and in_ready drops, so nothing is lost or repeated.
// Reset clears all valid bits and sets the sphere registers to zero.
module ray_sphere_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rsi_pkg::ray_t        in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rsi_pkg::hit_t        out_data
);
    import rsi_pkg::*;

    logic signed [CoordW-1:0] center_x_reg;
    logic signed [CoordW-1:0] center_y_reg;
    logic signed [CoordW-1:0] center_z_reg;
    logic [RadW-1:0]          radius_reg;
    logic                     wr_en;

    logic                     en;
    logic                     q_valid;
    logic [DiscW-1:0]         q_disc;
    coef_t                    q_coef;
    logic                     s_valid;
    logic [RootW-1:0]         s_root;
    coef_t                    s_coef;
    logic                     d_valid;
    logic                     d_miss;
    logic signed [31:0]       d_t0;
    logic signed [31:0]       d_t1;

    logic                     out_valid_reg;
    hit_t                     out_data_reg;
    hit_t                     out_data_next;

    // configuration registers
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            radius_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_CENTER_X: center_x_reg <= pwdata;
                REG_CENTER_Y: center_y_reg <= pwdata;
                REG_CENTER_Z: center_z_reg <= pwdata;
                REG_RADIUS:   radius_reg   <= pwdata[RadW-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_CENTER_X: prdata = center_x_reg;
            REG_CENTER_Y: prdata = center_y_reg;
            REG_CENTER_Z: prdata = center_z_reg;
            REG_RADIUS:   prdata = {1'b0, radius_reg};
            default:      prdata = '0;
        endcase
    end

    // pipeline advance
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    rsi_quad u_quad (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .ray       (in_data),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .center_z  (center_z_reg),
        .radius    (radius_reg),
        .out_valid (q_valid),
        .disc      (q_disc),
        .coef      (q_coef)
    );

    rsi_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_valid),
        .disc      (q_disc),
        .in_coef   (q_coef),
        .out_valid (s_valid),
        .root      (s_root),
        .out_coef  (s_coef)
    );

    rsi_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_valid),
        .root      (s_root),
        .coef      (s_coef),
        .out_valid (d_valid),
        .miss      (d_miss),
        .t0        (d_t0),
        .t1        (d_t1)
    );

    // result classification
    always_comb
    begin
        out_data_next.hit_count = HIT_NONE;
        out_data_next.t_near    = '0;
        out_data_next.t_far     = '0;
        if (!d_miss && !d_t1[31])
        begin
            out_data_next.t_near = d_t0;
            if (d_t0 != d_t1)
            begin
                out_data_next.hit_count = HIT_TWO;
                out_data_next.t_far     = d_t1;
            end
            else
                out_data_next.hit_count = HIT_ONE;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the ray/sphere intersection unit.
`timescale 1ns / 1ps

module tb;
    import rsi_pkg::*;

    localparam int FRAC      = 16;
    localparam int LATENCY   = 105;
    localparam int N_RANDOM  = 950;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    ray_t        in_data;
    logic        out_valid;
    logic        out_ready;
    hit_t        out_data;

    ray_sphere_intersect #(.FRAC_BITS(FRAC)) dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    // Sphere copy held by the predictor
    logic signed [31:0] sph_cx, sph_cy, sph_cz;
    logic [30:0]        sph_r;

    hit_t hits_pending[$];
    int   mismatches;
    int   send_idle_pct;
    int   recv_idle_pct;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Floor integer square root, bit by bit
    function automatic logic [63:0] isqrt_floor(logic [127:0] x);
        logic [63:0]  root;
        logic [63:0]  cand;
        root = '0;
        for (int k = 63; k >= 0; k--)
        begin
            cand = root | (64'd1 << k);
            if ({64'd0, cand} * {64'd0, cand} <= x)
                root = cand;
        end
        return root;
    endfunction

    // floor(num / den), den > 0, saturated to 32 bits
    function automatic logic signed [31:0] div_floor_sat(logic signed [199:0] num,
                                                        logic signed [199:0] den);
        logic signed [199:0] q;
        q = num / den;
        if ((num % den != 0) && (num < 0))
            q = q - 1;
        if (q < -200'sd2147483648)
            return T_MIN;
        if (q > 200'sd2147483647)
            return T_MAX;
        return q[31:0];
    endfunction

    // Expected hit for one ray against the current sphere
    function automatic hit_t sphere_hit(ray_t ray);
        hit_t                r;
        logic signed [199:0] lx, ly, lz, dx, dy, dz, rr;
        logic signed [199:0] a, h, c, disc, s, n0, n1;
        logic signed [31:0]  t0, t1;
        r  = '0;
        lx = 200'(signed'(ray.origin_x)) - 200'(sph_cx);
        ly = 200'(signed'(ray.origin_y)) - 200'(sph_cy);
        lz = 200'(signed'(ray.origin_z)) - 200'(sph_cz);
        dx = 200'(signed'(ray.dir_x));
        dy = 200'(signed'(ray.dir_y));
        dz = 200'(signed'(ray.dir_z));
        rr = 200'(signed'({1'b0, sph_r}));
        a  = dx * dx + dy * dy + dz * dz;
        if (a == 0)
            return r;
        h    = dx * lx + dy * ly + dz * lz;
        c    = lx * lx + ly * ly + lz * lz - rr * rr;
        disc = h * h - a * c;
        if (disc < 0)
            return r;
        s  = 200'(isqrt_floor(disc[127:0]));
        n0 = (-h - s) <<< FRAC;
        n1 = (-h + s) <<< FRAC;
        t0 = div_floor_sat(n0, a);
        t1 = div_floor_sat(n1, a);
        if (t1 < 0)
            return r;
        r.hit_count = (t0 != t1) ? HIT_TWO : HIT_ONE;
        r.t_near    = t0;
        r.t_far     = (t0 != t1) ? t1 : 32'sd0;
        return r;
    endfunction

    // APB register write: setup then access
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CENTER_X: sph_cx = value;
            REG_CENTER_Y: sph_cy = value;
            REG_CENTER_Z: sph_cz = value;
            default:      sph_r  = value[30:0];
        endcase
    endtask

    task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [31:0] rad);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_RADIUS, rad);
    endtask

    // Send one ray; expectation is queued when accepted
    task automatic send_ray(ray_t ray);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ray;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        hits_pending.push_back(sphere_hit(ray));
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (hits_pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
            default: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
        endcase
    endfunction

    // Ray aimed roughly at the sphere center, or away from it one time in four
    function automatic ray_t aimed_ray();
        ray_t ray;
        int   mode;
        mode         = $urandom_range(2);
        ray.origin_x = sph_cx + rand_coord(mode);
        ray.origin_y = sph_cy + rand_coord(mode);
        ray.origin_z = sph_cz + rand_coord(mode);
        ray.dir_x    = (sph_cx - ray.origin_x) + 32'($signed($urandom_range(4096)) - 2048);
        ray.dir_y    = (sph_cy - ray.origin_y) + 32'($signed($urandom_range(4096)) - 2048);
        ray.dir_z    = (sph_cz - ray.origin_z) + 32'($signed($urandom_range(4096)) - 2048);
        if ($urandom_range(3) == 0)
        begin
            ray.dir_x = -ray.dir_x;
            ray.dir_y = -ray.dir_y;
            ray.dir_z = -ray.dir_z;
        end
        return ray;
    endfunction

    // Receiver with random stalls; compares against oldest expectation
    always @(posedge clk)
    begin
        hit_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (hits_pending.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: %0d %h %h", out_data.hit_count,
                                 out_data.t_near, out_data.t_far);
                end
                else
                begin
                    want = hits_pending.pop_front();
                    if (want !== out_data)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: want %0d %h %h got %0d %h %h",
                                     want.hit_count, want.t_near, want.t_far,
                                     out_data.hit_count, out_data.t_near, out_data.t_far);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    typedef struct {
        ray_t ray;
        logic check_fixed;
        hit_t fixed;
    } dir_row_t;

    // Main sequence
    initial
    begin
        dir_row_t rows[$];
        ray_t     ray;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_ready  = 1'b0;
        mismatches = 0;
        sph_cx = 0; sph_cy = 0; sph_cz = 0; sph_r = 0;
        send_idle_pct = 36;
        recv_idle_pct = 45;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: at reset the sphere is a point at the origin
        rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1'b1, '{HIT_NONE, 0, 0}});
        rows.push_back('{'{-(1 << 16), 0, 0, 1 << 16, 0, 0}, 1'b1, '{HIT_ONE, 1 << 16, 0}});
        rows.push_back('{'{0, 0, 0, 0, 1 << 16, 0}, 1'b1, '{HIT_ONE, 0, 0}});
        rows.push_back('{'{1 << 16, 0, 0, 1 << 16, 0, 0}, 1'b1, '{HIT_NONE, 0, 0}});
        rows.push_back('{'{T_MIN, T_MIN, T_MIN, T_MAX, T_MAX, T_MAX}, 1'b0, '0});
        rows.push_back('{'{T_MAX, T_MAX, T_MAX, T_MIN, T_MIN, T_MIN}, 1'b0, '0});
        rows.push_back('{'{T_MIN, 0, 0, 1, 0, 0}, 1'b0, '0});
        rows.push_back('{'{-1, -1, -1, 1, 1, 1}, 1'b0, '0});
        rows.push_back('{'{-1, -1, -1, -1, -1, -1}, 1'b0, '0});
        foreach (rows[i])
        begin
            send_ray(rows[i].ray);
            if (rows[i].check_fixed)
                hits_pending[$] = rows[i].fixed;
        end
        drain();

        // Directed with unit sphere and an extreme sphere
        set_sphere(0, 0, 0, 1 << 16);
        send_ray('{-(4 << 16), 0, 0, 1 << 16, 0, 0});
        send_ray('{0, 1 << 16, -(4 << 16), 0, 0, 1 << 16});
        send_ray('{0, 0, 0, 1, 0, 0});
        send_ray('{0, 0, 0, 0, 0, 0});
        send_ray('{4 << 16, 0, 0, 1 << 16, 0, 0});
        send_ray('{0, 0, 0, T_MAX, T_MAX, T_MAX});
        drain();
        set_sphere(T_MAX, T_MIN, T_MAX, 32'h7fffffff);
        send_ray('{0, 0, 0, 1 << 16, 0, 0});
        send_ray('{T_MIN, T_MAX, T_MIN, T_MAX, T_MIN, T_MAX});
        send_ray('{T_MAX, T_MIN, T_MAX, 0, 0, 1});
        drain();

        // Random phases across idling profiles and sphere settings
        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle_pct = (ph < 2) ? 36 : (ph < 4) ? 45 : 0;
            recv_idle_pct = (ph < 2) ? 45 : (ph < 4) ? 36 : 0;
            if (ph == 5)
                set_sphere($urandom(), $urandom(), $urandom(), $urandom());
            else
                set_sphere(rand_coord(ph % 3), rand_coord(ph % 3), rand_coord(ph % 3),
                           $urandom_range(1 << 18));
            for (int n = 0; n < N_RANDOM / 6; n++)
            begin
                if ($urandom_range(4) == 0)
                    ray = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom()};
                else
                    ray = aimed_ray();
                send_ray(ray);
            end
            drain();
        end

        if (hits_pending.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("ray_sphere_intersect test passed");
        else
            $display("ray_sphere_intersect test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("ray_sphere_intersect test failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/rsi_pkg.sv
hdl/rsi_quad.sv
hdl/rsi_sqrt.sv
hdl/rsi_div.sv
hdl/ray_sphere_intersect.sv
dv/tb.sv
